### design/cbi_pkg.sv
package cbi_pkg;

  // field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned FracW   = 3;
  localparam int unsigned WgtW    = 7;
  localparam int unsigned SumW    = 14;
  localparam int unsigned WgtShift = 6;

  // default block geometry
  localparam int unsigned DefBlockSide = 4;

  // bilinear constants
  localparam logic [FracW:0]  FracOne   = 4'd8;
  localparam logic [SumW-1:0] RoundBias = 14'd32;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [FracW-1:0]   frac_t;

  // one cb/cr pair as held in the tap line
  typedef struct packed {
    sample_t cr;
    sample_t cb;
  } pair_t;

  // weights in order: top left, top right, bottom left, bottom right
  typedef logic [3:0][WgtW-1:0] weight_set_t;

  // 2x2 neighborhood of one component
  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t d;
  } quad_t;

  // operands handed from the window to the lanes
  typedef struct packed {
    logic        emit;
    logic        last;
    weight_set_t wgt;
    quad_t       cb;
    quad_t       cr;
  } win_op_t;

  // the four bilinear weights from the eighth-sample fractions
  function automatic weight_set_t calc_weights(frac_t fx, frac_t fy);
    logic [FracW:0]     ix;
    logic [FracW:0]     iy;
    logic [FracW:0]     x;
    logic [FracW:0]     y;
    logic [2*FracW+1:0] ix_w;
    logic [2*FracW+1:0] iy_w;
    logic [2*FracW+1:0] x_w;
    logic [2*FracW+1:0] y_w;
    logic [2*FracW+1:0] p0;
    logic [2*FracW+1:0] p1;
    logic [2*FracW+1:0] p2;
    logic [2*FracW+1:0] p3;
    weight_set_t        w;
    x  = {1'b0, fx};
    y  = {1'b0, fy};
    ix = FracOne - x;
    iy = FracOne - y;
    ix_w = {{(FracW+1){1'b0}}, ix};
    iy_w = {{(FracW+1){1'b0}}, iy};
    x_w  = {{(FracW+1){1'b0}}, x};
    y_w  = {{(FracW+1){1'b0}}, y};
    p0 = ix_w * iy_w;
    p1 = x_w * iy_w;
    p2 = ix_w * y_w;
    p3 = x_w * y_w;
    w[0] = p0[WgtW-1:0];
    w[1] = p1[WgtW-1:0];
    w[2] = p2[WgtW-1:0];
    w[3] = p3[WgtW-1:0];
    return w;
  endfunction

endpackage

### design/cbi_lane.sv
module cbi_lane (
  input  cbi_pkg::weight_set_t wgt_i,
  input  cbi_pkg::quad_t       quad_i,
  output cbi_pkg::sample_t     pred_o
);
  import cbi_pkg::*;

  logic [SumW-1:0] prod_a;
  logic [SumW-1:0] prod_b;
  logic [SumW-1:0] prod_c;
  logic [SumW-1:0] prod_d;
  logic [SumW-1:0] sum;

  // weighted taps, weights sum to 64 so the total stays below 2^14
  assign prod_a = SumW'(wgt_i[0]) * SumW'(quad_i.a);
  assign prod_b = SumW'(wgt_i[1]) * SumW'(quad_i.b);
  assign prod_c = SumW'(wgt_i[2]) * SumW'(quad_i.c);
  assign prod_d = SumW'(wgt_i[3]) * SumW'(quad_i.d);

  // round and scale back to sample range
  assign sum    = prod_a + prod_b + prod_c + prod_d + RoundBias;
  assign pred_o = sum[WgtShift +: SampleW];

endmodule

### design/cbi_window.sv
module cbi_window #(
  parameter int unsigned BlockSide = cbi_pkg::DefBlockSide
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  cbi_pkg::pair_t   cur_i,
  input  cbi_pkg::frac_t   frac_x_i,
  input  cbi_pkg::frac_t   frac_y_i,
  output cbi_pkg::win_op_t op_o
);
  import cbi_pkg::*;

  localparam int unsigned WinSide = BlockSide + 1;
  localparam int unsigned CntW    = $clog2(WinSide);
  localparam logic [CntW-1:0] CntLast = CntW'(WinSide - 1);

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  weight_set_t     wgt_q, wgt_d;
  logic            first;

  // tap line: entry 0 is the previous word, entry WinSide-1 the word above,
  // entry WinSide the word above and to the left
  pair_t tap_q [WinSide+1];
  pair_t top_l;
  pair_t top_r;
  pair_t left;

  assign first = (col_q == '0) && (row_q == '0);
  assign left  = tap_q[0];
  assign top_r = tap_q[WinSide-1];
  assign top_l = tap_q[WinSide];

  // weights latched with the first word of a window
  always_comb begin
    wgt_d = wgt_q;
    if (first) begin
      wgt_d = calc_weights(frac_x_i, frac_y_i);
    end
  end

  // raster position within the window
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_q == CntLast) begin
      col_d = '0;
      row_d = (row_q == CntLast) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      wgt_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      wgt_q <= wgt_d;
    end
  end

  // shift line of past words
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tap_q[0] <= cur_i;
      for (int i = 1; i <= WinSide; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  // neighborhood of the current word
  always_comb begin
    op_o.emit = (col_q != '0) && (row_q != '0);
    op_o.last = (col_q == CntLast) && (row_q == CntLast);
    op_o.wgt  = wgt_d;
    op_o.cb.a = top_l.cb;
    op_o.cb.b = top_r.cb;
    op_o.cb.c = left.cb;
    op_o.cb.d = cur_i.cb;
    op_o.cr.a = top_l.cr;
    op_o.cr.b = top_r.cr;
    op_o.cr.c = left.cr;
    op_o.cr.d = cur_i.cr;
  end

endmodule

### design/chroma_bilinear_interpolator_4x4_unit.sv
// channel | handshake               | word
// --------+-------------------------+--------------------------------------------
// input   | in_valid_i/in_ready_o   | cb_sample_i, cr_sample_i, frac_x_i, frac_y_i
// output  | out_valid_o/out_ready_i | cb_pred_o, cr_pred_o, block_last_o
//
// one input word per cycle while in_ready_o is high; the prediction for the word
// that completes its 2x2 neighborhood passes the operand register, then the output register
// words in row 0 or column 0 of the window produce nothing
// a held output lets the operand register still fill; the input stalls only
// once both the operand and the output register hold a prediction
// reset clears position counters, weights and valid flags
module chroma_bilinear_interpolator_4x4_unit #(
  parameter int unsigned BlockSide = cbi_pkg::DefBlockSide
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cbi_pkg::sample_t cb_sample_i,
  input  cbi_pkg::sample_t cr_sample_i,
  input  cbi_pkg::frac_t   frac_x_i,
  input  cbi_pkg::frac_t   frac_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbi_pkg::sample_t cb_pred_o,
  output cbi_pkg::sample_t cr_pred_o,
  output logic             block_last_o
);
  import cbi_pkg::*;

  logic    accept;
  logic    out_en;
  logic    s1_en;
  pair_t   cur;
  win_op_t op;

  logic    s1_vld_q;
  win_op_t s1_op_q;
  logic    out_vld_q;
  sample_t cb_pred_q;
  sample_t cr_pred_q;
  logic    last_q;
  sample_t cb_lane;
  sample_t cr_lane;

  // global stall
  assign out_en     = !out_vld_q || out_ready_i;
  assign s1_en      = !s1_vld_q || out_en;
  assign in_ready_o = s1_en;
  assign accept     = in_valid_i && in_ready_o;

  assign cur.cb = cb_sample_i;
  assign cur.cr = cr_sample_i;

  // window tracking and neighborhood gathering
  cbi_window #(
    .BlockSide(BlockSide)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cur_i   (cur),
    .frac_x_i(frac_x_i),
    .frac_y_i(frac_y_i),
    .op_o    (op)
  );

  // operand register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_en) begin
      s1_vld_q <= accept && op.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_op_q <= op;
    end
  end

  // one lane per chroma component
  cbi_lane u_lane_cb (
    .wgt_i (s1_op_q.wgt),
    .quad_i(s1_op_q.cb),
    .pred_o(cb_lane)
  );

  cbi_lane u_lane_cr (
    .wgt_i (s1_op_q.wgt),
    .quad_i(s1_op_q.cr),
    .pred_o(cr_lane)
  );

  // merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      cb_pred_q <= cb_lane;
      cr_pred_q <= cr_lane;
      last_q    <= s1_op_q.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cb_pred_o    = cb_pred_q;
  assign cr_pred_o    = cr_pred_q;
  assign block_last_o = last_q;

endmodule
